// File: rtl/core/rlisu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLP list item splitter package
// Shared types, codes and constants of the list item splitter.
// ----------------------------------------------------------------------------
package rlisu_pkg;

  localparam int MAX_ITEMS_DEF = 255;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_LEN     = 2'd2;
  localparam logic [1:0] ST_FMT     = 2'd3;

  localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;
  localparam logic [7:0] LIST_SHORT_MAX  = 8'hf7;
  localparam logic [7:0] LIST_LONG_MAX   = 8'hfb;
  localparam logic [7:0] SINGLE_MAX      = 8'h7f;
  localparam logic [7:0] STR_SHORT_MAX   = 8'hb7;
  localparam logic [7:0] STR_LONG_MAX    = 8'hbb;
  localparam logic [7:0] EMPTY_LIST      = 8'hc0;

  localparam logic [0:0] REG_EXPECTED_ITEMS = 1'b0;

  typedef enum logic [1:0] {
    LK_BAD,
    LK_SHORT,
    LK_LONG
  } lkind_t;

  typedef enum logic [2:0] {
    IK_SINGLE,
    IK_SHORT,
    IK_LONG,
    IK_EMPTY,
    IK_BAD
  } ikind_t;

  typedef enum logic [6:0] {
    PH_LHDR   = 7'b0000001,
    PH_LLEN   = 7'b0000010,
    PH_IHDR   = 7'b0000100,
    PH_ILEN   = 7'b0001000,
    PH_IFIRST = 7'b0010000,
    PH_IDATA  = 7'b0100000,
    PH_DRAIN  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    lkind_t     lkind;
    ikind_t     ikind;
    logic [2:0] nlen;
  } entry_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] item_index;
    logic       item_first;
    logic       item_last;
    logic       empty_item;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] items_found;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/rlp_list_item_splitter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLP list item splitter
// Splits one flat RLP-encoded list, fed a byte at a time, into its items.
// ----------------------------------------------------------------------------
// Each input item is one byte of the encoded list, with a mark on the final
// byte of the buffer. Every input item yields exactly one result item that
// carries a payload byte with its item index and first and last marks, an
// empty item mark, or nothing; the result of the final byte also carries the
// status and the number of items found.
// The expected item count is written over the APB port at address 0 and kept
// across lists; the user writes it only while the block is idle (not enforced).
// A byte is classified as it is accepted, waits in a two-entry queue, is parsed
// at the queue head, and its result is held in the output register.
// One byte is accepted per cycle while the receiver takes results; the rate is
// set by the parse step, which updates the length counters and the phase.
// When the receiver stalls, the result stays in the output register, the
// queue fills, and input ready falls once the queue is full.
// Reset empties the queue, clears the parse state and the expected count.
// ----------------------------------------------------------------------------
module rlp_list_item_splitter_unit
  import rlisu_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_data_valid,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_item_index,
  output logic             out_item_first,
  output logic             out_item_last,
  output logic             out_empty_item,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic [7:0]       out_items_found
);

  logic [7:0] expected_items_r;
  logic       q_full;
  logic       q_push;
  entry_t     q_wr_entry;
  logic       q_pop;
  logic       q_valid;
  entry_t     q_rd_entry;
  result_t    res;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_EXPECTED_ITEMS) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_sel ? {24'd0, expected_items_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_items_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      expected_items_r <= pwdata[7:0];
    end
  end

  rlisu_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  rlisu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_rd_entry)
  );

  rlisu_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_rd_entry),
    .q_pop          (q_pop),
    .expected_items (expected_items_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (res)
  );

  assign out_data_valid  = res.data_valid;
  assign out_data_byte   = res.data_byte;
  assign out_item_index  = res.item_index;
  assign out_item_first  = res.item_first;
  assign out_item_last   = res.item_last;
  assign out_empty_item  = res.empty_item;
  assign out_done_res    = res.done_res;
  assign out_status      = res.status;
  assign out_items_found = res.items_found;

  a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_items_found != 8'd0) |-> (out_done_res && out_status == ST_OK))
    else $error("items found reported without a good status");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_status == ST_OK))
    else $error("status reported on a byte that is not the last");

  a_marks_need_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_valid) |-> (!out_item_first && !out_item_last))
    else $error("first or last mark on an item without payload");

  a_empty_not_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_item) |-> !out_data_valid)
    else $error("empty mark together with payload");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !in_ready) |=> !in_ready || out_ready || !out_valid)
    else $error("queue drained while the receiver stalled");

endmodule
`default_nettype wire

// File: rtl/core/rlisu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLP list item splitter front end
// Accepts input items and classifies each byte as list and item header.
// ----------------------------------------------------------------------------
module rlisu_front
  import rlisu_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_last_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output entry_t          q_entry
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.byte_val = in_byte_in;
    q_entry.last     = in_last_byte;
    q_entry.nlen     = {1'b0, in_byte_in[1:0]} + 3'd1;
    if (in_byte_in < LIST_SHORT_BASE || in_byte_in > LIST_LONG_MAX) begin
      q_entry.lkind = LK_BAD;
    end else if (in_byte_in <= LIST_SHORT_MAX) begin
      q_entry.lkind = LK_SHORT;
    end else begin
      q_entry.lkind = LK_LONG;
    end
    if (in_byte_in <= SINGLE_MAX) begin
      q_entry.ikind = IK_SINGLE;
    end else if (in_byte_in <= STR_SHORT_MAX) begin
      q_entry.ikind = IK_SHORT;
    end else if (in_byte_in <= STR_LONG_MAX) begin
      q_entry.ikind = IK_LONG;
    end else if (in_byte_in == EMPTY_LIST) begin
      q_entry.ikind = IK_EMPTY;
    end else begin
      q_entry.ikind = IK_BAD;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rlisu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLP list item splitter queue
// Short queue of classified items between the front end and the parser.
// ----------------------------------------------------------------------------
module rlisu_queue
  import rlisu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        rd_valid,
  output entry_t      rd_entry
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && rd_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && rd_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && rd_valid) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rlisu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLP list item splitter parser
// Runs the list parse state, counts lengths and registers each result item.
// ----------------------------------------------------------------------------
module rlisu_back
  import rlisu_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire entry_t     q_entry,
  output logic            q_pop,
  input  wire logic [7:0] expected_items,
  output logic            out_valid,
  input  wire logic       out_ready,
  output result_t         out_res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  lbl_r, lbl_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] pl_r, pl_nxt;
  logic [31:0] ibl_r, ibl_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res;
  logic        proc;
  logic        fmt;
  logic [31:0] pl_dec;
  logic [31:0] acc_new;
  logic [2:0]  lbl_new;
  logic [31:0] ib_dec;
  logic [31:0] len6;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    phase_nxt = phase_r;
    lbl_nxt   = lbl_r;
    acc_nxt   = acc_r;
    ibl_nxt   = ibl_r;
    cur_nxt   = cur_r;
    held_nxt  = held_r;
    ovf_nxt   = ovf_r;
    res       = '0;
    proc      = 1'b1;
    fmt       = 1'b0;
    pl_dec    = pl_r;
    acc_new   = {acc_r[23:0], q_entry.byte_val};
    lbl_new   = lbl_r - 3'd1;
    ib_dec    = ibl_r;
    len6      = {26'd0, q_entry.byte_val[5:0]};

    if (phase_r != PH_LHDR && phase_r != PH_LLEN && held_r != ST_BAD_HDR) begin
      if (pl_r == '0) begin
        ovf_nxt = 1'b1;
        proc    = 1'b0;
      end else begin
        pl_dec = pl_r - 32'd1;
      end
    end
    pl_nxt = pl_dec;

    if (proc) begin
      case (phase_r)
        PH_LHDR: begin
          case (q_entry.lkind)
            LK_SHORT: begin
              pl_nxt    = len6;
              phase_nxt = PH_IHDR;
            end
            LK_LONG: begin
              lbl_nxt   = q_entry.nlen;
              acc_nxt   = '0;
              phase_nxt = PH_LLEN;
            end
            default: begin
              held_nxt  = ST_BAD_HDR;
              phase_nxt = PH_DRAIN;
            end
          endcase
        end
        PH_LLEN: begin
          acc_nxt = acc_new;
          lbl_nxt = lbl_new;
          if (lbl_new == '0) begin
            pl_nxt    = acc_new;
            phase_nxt = PH_IHDR;
          end
        end
        PH_IHDR: begin
          if (cur_r >= expected_items || 32'(cur_r) >= 32'(MAX_ITEMS)) begin
            fmt = 1'b1;
          end else begin
            case (q_entry.ikind)
              IK_SINGLE: begin
                res.data_valid = 1'b1;
                res.data_byte  = q_entry.byte_val;
                res.item_index = cur_r;
                res.item_first = 1'b1;
                res.item_last  = 1'b1;
                cur_nxt        = cur_r + 8'd1;
              end
              IK_SHORT: begin
                if (len6 == '0) begin
                  res.empty_item = 1'b1;
                  res.item_index = cur_r;
                  cur_nxt        = cur_r + 8'd1;
                end else if (len6 > pl_dec) begin
                  fmt = 1'b1;
                end else begin
                  ibl_nxt   = len6;
                  phase_nxt = PH_IFIRST;
                end
              end
              IK_LONG: begin
                if (32'(q_entry.nlen) > pl_dec) begin
                  fmt = 1'b1;
                end else begin
                  lbl_nxt   = q_entry.nlen;
                  acc_nxt   = '0;
                  phase_nxt = PH_ILEN;
                end
              end
              IK_EMPTY: begin
                res.empty_item = 1'b1;
                res.item_index = cur_r;
                cur_nxt        = cur_r + 8'd1;
              end
              default: begin
                fmt = 1'b1;
              end
            endcase
          end
        end
        PH_ILEN: begin
          acc_nxt = acc_new;
          lbl_nxt = lbl_new;
          if (lbl_new == '0) begin
            if (acc_new == '0) begin
              res.empty_item = 1'b1;
              res.item_index = cur_r;
              cur_nxt        = cur_r + 8'd1;
              phase_nxt      = PH_IHDR;
            end else if (acc_new > pl_dec) begin
              fmt = 1'b1;
            end else begin
              ibl_nxt   = acc_new;
              phase_nxt = PH_IFIRST;
            end
          end
        end
        PH_IFIRST, PH_IDATA: begin
          res.data_valid = 1'b1;
          res.data_byte  = q_entry.byte_val;
          res.item_index = cur_r;
          res.item_first = (phase_r == PH_IFIRST);
          if (ibl_r != '0) begin
            ib_dec = ibl_r - 32'd1;
          end
          ibl_nxt = ib_dec;
          if (ib_dec == '0) begin
            res.item_last = 1'b1;
            cur_nxt       = cur_r + 8'd1;
            phase_nxt     = PH_IHDR;
          end else begin
            phase_nxt = PH_IDATA;
          end
        end
        default: begin
        end
      endcase
    end

    if (fmt) begin
      held_nxt  = ST_FMT;
      phase_nxt = PH_DRAIN;
    end

    if (q_entry.last) begin
      res.done_res = 1'b1;
      if (held_nxt == ST_BAD_HDR) begin
        res.status = ST_BAD_HDR;
      end else if (phase_nxt == PH_LLEN || pl_nxt != '0 || ovf_nxt) begin
        res.status = ST_LEN;
      end else if (held_nxt == ST_FMT) begin
        res.status = ST_FMT;
      end else if (cur_nxt != expected_items || phase_nxt != PH_IHDR) begin
        res.status = ST_FMT;
      end else begin
        res.status      = ST_OK;
        res.items_found = cur_nxt;
      end
      phase_nxt = PH_LHDR;
      lbl_nxt   = '0;
      acc_nxt   = '0;
      pl_nxt    = '0;
      ibl_nxt   = '0;
      cur_nxt   = '0;
      held_nxt  = ST_OK;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LHDR;
      lbl_r       <= '0;
      acc_r       <= '0;
      pl_r        <= '0;
      ibl_r       <= '0;
      cur_r       <= '0;
      held_r      <= ST_OK;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        lbl_r   <= lbl_nxt;
        acc_r   <= acc_nxt;
        pl_r    <= pl_nxt;
        ibl_r   <= ibl_nxt;
        cur_r   <= cur_nxt;
        held_r  <= held_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire
